// ===== hdl/hisc_pkg.sv =====
package hisc_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned MUL_W        = 33;
  localparam int unsigned PROD_W       = 66;
  localparam int unsigned ACC_W        = 66;
  localparam int unsigned QUO_W        = 48;
  localparam int unsigned QS_W         = 50;
  localparam int unsigned DIFF_W       = 51;
  localparam int unsigned DIST_W       = 48;
  localparam int unsigned SUM_W        = 50;
  localparam int unsigned INDEX_W      = 16;
  localparam int unsigned TOTAL_W      = 17;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned S_TDATA_W    = 192;
  localparam int unsigned M_TDATA_W    = 40;
  localparam int unsigned M_TUSER_W    = 2;
  localparam int unsigned DIV_STEPS    = 48;
  localparam int unsigned DIV_CNT_W    = 6;
  localparam int unsigned NUM_COEF     = 9;
  localparam int unsigned K_W          = 4;

  localparam int unsigned MAX_POINTS_DEF     = 65536;
  localparam int unsigned COEF_FRAC_BITS_DEF = 20;

  localparam logic [WORD_W-1:0]  COEF_ONE    = 32'h0010_0000;
  localparam logic [DIST_W-1:0]  DIST_SAT    = 48'hFFFF_FFFF_FFFF;
  localparam logic [TOTAL_W-1:0] INLIER_CAP  = 17'h1_0000;

  localparam logic [CFG_IDX_W-1:0] REG_H00_H01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H02_H10 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H11_H12 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H20_H21 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H22     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_DINIT,
    OP_DSTEP,
    OP_DEND,
    OP_SQMUL,
    OP_SQACC,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e          op;
    logic [K_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic zero_depth;
  } sts_t;

endpackage

// ===== hdl/hisc_ctrl.sv =====
module hisc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  hisc_pkg::sts_t sts_i,
  output hisc_pkg::cmd_t cmd_o
);
  import hisc_pkg::*;

  state_e               state_q, state_d;
  logic [K_W-1:0]       k_q, k_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 sel_q, sel_d;
  logic                 valid_q, valid_d;
  logic                 out_free;

  assign out_free      = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_MUL;
          k_d     = '0;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (k_q == K_W'(NUM_COEF - 1)) begin
          state_d = ST_CHECK;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_CHECK: begin
        sel_d   = 1'b0;
        state_d = sts_i.zero_depth ? ST_OUT : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DIV_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV_END: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_DIV_INIT;
        end else begin
          k_d     = '0;
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: state_d = ST_SQ_ACC;
      ST_SQ_ACC: begin
        if (k_q == K_W'(2)) begin
          state_d = ST_OUT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.idx = k_q;
    valid_d   = valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE:     if (s_axis_tvalid) cmd_o.op = OP_LOAD;
      ST_MUL:      cmd_o.op = OP_MUL;
      ST_ACC:      cmd_o.op = OP_ACC;
      ST_CHECK:    cmd_o.op = OP_NONE;
      ST_DIV_INIT: begin
        cmd_o.op  = OP_DINIT;
        cmd_o.idx = K_W'(sel_q);
      end
      ST_DIV_STEP: cmd_o.op = OP_DSTEP;
      ST_DIV_END: begin
        cmd_o.op  = OP_DEND;
        cmd_o.idx = K_W'(sel_q);
      end
      ST_SQ_MUL:   cmd_o.op = OP_SQMUL;
      ST_SQ_ACC:   cmd_o.op = OP_SQACC;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op = OP_OUT;
          valid_d  = 1'b1;
        end
      end
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/hisc_dpath.sv =====
module hisc_dpath #(
  parameter int unsigned MAX_POINTS     = hisc_pkg::MAX_POINTS_DEF,
  parameter int unsigned COEF_FRAC_BITS = hisc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hisc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hisc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [hisc_pkg::S_TDATA_W-1:0]     s_tdata_i,
  input  logic                               s_tlast_i,
  input  hisc_pkg::cmd_t                     cmd_i,
  output hisc_pkg::sts_t                     sts_o,
  output logic [hisc_pkg::INDEX_W-1:0]       point_index_o,
  output logic                               inlier_flag_o,
  output logic [hisc_pkg::TOTAL_W-1:0]       inlier_total_o,
  output logic                               zero_depth_o,
  output logic                               set_done_o
);
  import hisc_pkg::*;

  logic [WORD_W-1:0]        h_q [NUM_COEF];
  logic [DIST_W-1:0]        thr_q;
  logic signed [WORD_W-1:0] sx_q, sy_q, sw_q, tx_q, ty_q, tw_q;
  logic                     last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q [3];
  logic [ACC_W:0]           r_q;
  logic [QUO_W-1:0]         sh_q, quo_q;
  logic                     sat_q, neg_q, big_q;
  logic signed [QS_W-1:0]   qx_q, qy_q;
  logic [SUM_W-1:0]         dist_q;
  logic [INDEX_W-1:0]       pts_q;
  logic [TOTAL_W-1:0]       inl_q;

  logic signed [ACC_W-1:0]  pw_fl, num;
  logic [ACC_W-1:0]         n_mag, d_mag;
  logic [ACC_W:0]           trial;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [WORD_W-1:0] src_sel;
  logic [1:0]               row;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        dmag;
  logic [QUO_W:0]           qmag;
  logic [DIST_W-1:0]        term, dist_c;
  logic                     inl;
  logic [TOTAL_W-1:0]       inl_nx;
  logic [TOTAL_W-1:0]       pts_nx;

  // projected depth and selected numerator, floored to Q16.16
  assign pw_fl = acc_q[2] >>> COEF_FRAC_BITS;
  assign num   = cmd_i.idx[0] ? (acc_q[1] >>> COEF_FRAC_BITS)
                              : (acc_q[0] >>> COEF_FRAC_BITS);
  assign n_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign d_mag = pw_fl[ACC_W-1] ? ACC_W'(-pw_fl) : ACC_W'(pw_fl);
  assign trial = {r_q[ACC_W-1:0], sh_q[QUO_W-1]};
  assign sts_o.zero_depth = (pw_fl == '0);

  always_comb begin
    case (cmd_i.idx) inside
      4'd0, 4'd3, 4'd6: src_sel = sx_q;
      4'd1, 4'd4, 4'd7: src_sel = sy_q;
      default:          src_sel = sw_q;
    endcase
    case (cmd_i.idx) inside
      [4'd0:4'd2]: row = 2'd0;
      [4'd3:4'd5]: row = 2'd1;
      default:     row = 2'd2;
    endcase
  end

  // distance terms
  always_comb begin
    case (cmd_i.idx)
      4'd0:    diff = DIFF_W'(qx_q) - DIFF_W'(tx_q);
      4'd1:    diff = DIFF_W'(qy_q) - DIFF_W'(ty_q);
      default: diff = DIFF_W'(65536) - DIFF_W'(tw_q);
    endcase
    dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  always_comb begin
    if (cmd_i.op == OP_SQMUL) begin
      mul_a = $signed({1'b0, dmag[WORD_W-1:0]});
      mul_b = $signed({1'b0, dmag[WORD_W-1:0]});
    end else begin
      mul_a = MUL_W'($signed(h_q[cmd_i.idx]));
      mul_b = MUL_W'(src_sel);
    end
  end

  assign qmag   = sat_q ? {1'b1, QUO_W'(0)} : {1'b0, quo_q};
  assign term   = big_q ? DIST_SAT : prod_q[DIST_W+15:16];
  assign dist_c = (dist_q > SUM_W'(DIST_SAT)) ? DIST_SAT : dist_q[DIST_W-1:0];
  assign inl    = !sts_o.zero_depth && (dist_c < thr_q);
  assign inl_nx = (inl && inl_q < INLIER_CAP) ? inl_q + 1'b1 : inl_q;
  assign pts_nx = {1'b0, pts_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= COEF_ONE;
      h_q[1] <= '0;
      h_q[2] <= '0;
      h_q[3] <= '0;
      h_q[4] <= COEF_ONE;
      h_q[5] <= '0;
      h_q[6] <= '0;
      h_q[7] <= '0;
      h_q[8] <= COEF_ONE;
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_H00_H01: begin
          h_q[0] <= cfg_data_i[63:32];
          h_q[1] <= cfg_data_i[31:0];
        end
        REG_H02_H10: begin
          h_q[2] <= cfg_data_i[63:32];
          h_q[3] <= cfg_data_i[31:0];
        end
        REG_H11_H12: begin
          h_q[4] <= cfg_data_i[63:32];
          h_q[5] <= cfg_data_i[31:0];
        end
        REG_H20_H21: begin
          h_q[6] <= cfg_data_i[63:32];
          h_q[7] <= cfg_data_i[31:0];
        end
        REG_H22:    h_q[8] <= cfg_data_i[31:0];
        REG_THRESH: thr_q  <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= '0;
      inl_q <= '0;
    end else if (cmd_i.op == OP_OUT) begin
      if (last_q) begin
        pts_q <= '0;
        inl_q <= '0;
      end else begin
        inl_q <= inl_nx;
        if (pts_nx[INDEX_W] || (32'(pts_nx) >= MAX_POINTS)) pts_q <= '0;
        else pts_q <= pts_nx[INDEX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sx_q     <= s_tdata_i[31:0];
        sy_q     <= s_tdata_i[63:32];
        sw_q     <= s_tdata_i[95:64];
        tx_q     <= s_tdata_i[127:96];
        ty_q     <= s_tdata_i[159:128];
        tw_q     <= s_tdata_i[191:160];
        last_q   <= s_tlast_i;
        acc_q[0] <= '0;
        acc_q[1] <= '0;
        acc_q[2] <= '0;
        dist_q   <= '0;
      end
      OP_MUL: prod_q <= mul_a * mul_b;
      OP_ACC: acc_q[row] <= acc_q[row] + prod_q;
      OP_DINIT: begin
        r_q   <= (ACC_W+1)'(n_mag >> 32);
        sh_q  <= {n_mag[31:0], 16'd0};
        quo_q <= '0;
        sat_q <= (n_mag >> 32) >= d_mag;
        neg_q <= num[ACC_W-1] ^ pw_fl[ACC_W-1];
      end
      OP_DSTEP: begin
        sh_q <= {sh_q[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, d_mag}) begin
          r_q   <= trial - {1'b0, d_mag};
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          r_q   <= trial;
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      OP_DEND: begin
        if (cmd_i.idx[0]) qy_q <= neg_q ? -QS_W'(qmag) : QS_W'(qmag);
        else qx_q <= neg_q ? -QS_W'(qmag) : QS_W'(qmag);
      end
      OP_SQMUL: begin
        prod_q <= mul_a * mul_b;
        big_q  <= |dmag[DIFF_W-1:WORD_W];
      end
      OP_SQACC: dist_q <= dist_q + SUM_W'(term);
      OP_OUT: begin
        point_index_o  <= pts_q;
        inlier_flag_o  <= inl;
        inlier_total_o <= inl_nx;
        zero_depth_o   <= sts_o.zero_depth;
        set_done_o     <= last_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/homography_inlier_scorer.sv =====
// Homography inlier scorer: each input word is one correspondence (source and
// target points, homogeneous Q16.16) that is mapped through the 3x3 Q12.20
// homography, divided by the projected w and tested against the squared
// distance threshold; one result word gives the point index, inlier flag,
// running inlier count, a zero-depth flag and the end-of-set echo. One item at
// a time: after the accept, the nine products run on a single shared 33x33
// multiplier, then the depth check, the two divisions on a one-bit-per-cycle
// restoring divider and the three squares, then the output; divisions and
// squares are skipped when the projected w is zero. The next point is taken
// while the previous result waits in the output register.
module homography_inlier_scorer #(
  parameter int unsigned MAX_POINTS     = hisc_pkg::MAX_POINTS_DEF,
  parameter int unsigned COEF_FRAC_BITS = hisc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hisc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hisc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // source_x, source_y, source_w, target_x, target_y, target_w
  input  logic [hisc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // point_index, inlier_total, zero padding
  output logic [hisc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // inlier_flag, zero_depth
  output logic [hisc_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tlast
);
  import hisc_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [INDEX_W-1:0] point_index;
  logic [TOTAL_W-1:0] inlier_total;
  logic               inlier_flag, zero_depth;

  hisc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  hisc_dpath #(
    .MAX_POINTS     (MAX_POINTS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_tdata_i      (s_axis_tdata),
    .s_tlast_i      (s_axis_tlast),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .point_index_o  (point_index),
    .inlier_flag_o  (inlier_flag),
    .inlier_total_o (inlier_total),
    .zero_depth_o   (zero_depth),
    .set_done_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, inlier_total, point_index};
  assign m_axis_tuser = {zero_depth, inlier_flag};

  a_no_inlier_at_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("inlier flagged at zero depth");

  a_inlier_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[32:16] != '0))
    else $error("inlier with zero total");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while busy");

endmodule

// ===== verif/hisc_checker.sv =====
module hisc_checker #(
  parameter int unsigned MAX_POINTS     = hisc_pkg::MAX_POINTS_DEF,
  parameter int unsigned COEF_FRAC_BITS = hisc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hisc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hisc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // source_x, source_y, source_w, target_x, target_y, target_w
  input  logic [hisc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // point_index, inlier_total, zero padding
  input  logic [hisc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // inlier_flag, zero_depth
  input  logic [hisc_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  input  logic                              m_axis_tlast,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                scored_o,
  output int                                inliers_seen_o
);
  import hisc_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               inlier;
    logic [TOTAL_W-1:0] total;
    logic               zero_depth;
    logic               set_done;
  } score_t;

  logic [63:0]        h_regs [6];
  logic [TOTAL_W-1:0] inlier_cnt;
  logic [INDEX_W-1:0] point_cnt;
  score_t             score_q [$];
  int                 fails;
  int                 scored;
  int                 inl_seen;

  function automatic longint project_row(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] w);
    logic signed [95:0] ea, eb, ec, ex, ey, ew, acc;
    ea = a; eb = b; ec = c; ex = x; ey = y; ew = w;
    acc = ea * ex + eb * ey + ec * ew;
    acc = acc >>> COEF_FRAC_BITS;
    return longint'(acc);
  endfunction

  function automatic longint div_q16(longint num, longint den);
    longint unsigned n, d, mag;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (n / d >= 64'h1_0000_0000) mag = 64'd1 << 48;
    else mag = (n << 16) / d;
    return ((num < 0) != (den < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned square_q(longint v);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    if (mag >= 64'h1_0000_0000) return 64'(DIST_SAT);
    return (mag * mag) >> 16;
  endfunction

  function automatic logic signed [31:0] word_of(logic [63:0] r, bit upper);
    return upper ? r[63:32] : r[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_t             expd, act;
    logic signed [31:0] sx, sy, sw, tx, ty, tw;
    longint             px, py, pw, qx, qy;
    longint unsigned    sq_sum;
    logic [INDEX_W:0]   nxt;
    if (!rst_ni) begin
      h_regs[0] = 64'd4503599627370496;
      h_regs[1] = '0;
      h_regs[2] = 64'd4503599627370496;
      h_regs[3] = '0;
      h_regs[4] = 64'(COEF_ONE);
      h_regs[5] = '0;
      inlier_cnt = '0;
      point_cnt = '0;
      score_q.delete();
      fails = 0;
      scored = 0;
      inl_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_H00_H01, REG_H02_H10, REG_H11_H12, REG_H20_H21: h_regs[cfg_index_i] = cfg_data_i;
          REG_H22:    h_regs[4] = {32'd0, cfg_data_i[31:0]};
          REG_THRESH: h_regs[5] = {16'd0, cfg_data_i[47:0]};
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        {tw, ty, tx, sw, sy, sx} = s_axis_tdata;
        px = project_row(word_of(h_regs[0], 1), word_of(h_regs[0], 0),
                         word_of(h_regs[1], 1), sx, sy, sw);
        py = project_row(word_of(h_regs[1], 0), word_of(h_regs[2], 1),
                         word_of(h_regs[2], 0), sx, sy, sw);
        pw = project_row(word_of(h_regs[3], 1), word_of(h_regs[3], 0),
                         word_of(h_regs[4], 0), sx, sy, sw);
        expd.zero_depth = (pw == 0);
        expd.inlier = 1'b0;
        if (pw != 0) begin
          qx = div_q16(px, pw);
          qy = div_q16(py, pw);
          sq_sum = square_q(qx - longint'(tx)) + square_q(qy - longint'(ty))
                 + square_q(longint'(65536) - longint'(tw));
          if (sq_sum > 64'(DIST_SAT)) sq_sum = 64'(DIST_SAT);
          expd.inlier = sq_sum < h_regs[5];
        end
        if (expd.inlier && inlier_cnt < INLIER_CAP) inlier_cnt++;
        expd.index = point_cnt;
        expd.total = inlier_cnt;
        expd.set_done = s_axis_tlast;
        if (s_axis_tlast) begin
          inlier_cnt = '0;
          point_cnt = '0;
        end else begin
          nxt = {1'b0, point_cnt} + 1'b1;
          point_cnt = (nxt >= MAX_POINTS) ? '0 : nxt[INDEX_W-1:0];
        end
        score_q = {score_q, expd};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act.index = m_axis_tdata[15:0];
        act.total = m_axis_tdata[32:16];
        act.inlier = m_axis_tuser[0];
        act.zero_depth = m_axis_tuser[1];
        act.set_done = m_axis_tlast;
        scored++;
        if (act.inlier) inl_seen++;
        if (score_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %h", act);
        end else begin
          expd = score_q.pop_front();
          if (act !== expd) begin
            fails++;
            if (fails <= 10)
              $display("mismatch idx %0d/%0d inl %0d/%0d tot %0d/%0d zd %0d/%0d done %0d/%0d",
                       expd.index, act.index, expd.inlier, act.inlier, expd.total,
                       act.total, expd.zero_depth, act.zero_depth, expd.set_done,
                       act.set_done);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= score_q.size();
    scored_o <= scored;
    inliers_seen_o <= inl_seen;
  end
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import hisc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [S_TDATA_W-1:0]    s_axis_tdata;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  logic [M_TUSER_W-1:0]    m_axis_tuser;
  logic                    m_axis_tlast;
  int                      fail_count, pending, scored, inliers_seen;
  int                      send_idle, recv_idle;
  logic                    hold_req;
  logic                    hold_ack = 1'b0;
  int                      hold_left = 0;
  int                      cycles = 0;

  homography_inlier_scorer dut (.*);

  hisc_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .scored_o(scored),
    .inliers_seen_o(inliers_seen)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver side, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_ack) begin
      hold_ack <= 1'b1;
      hold_left <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_point(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sw, input logic [31:0] tx,
                            input logic [31:0] ty, input logic [31:0] tw, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tw, ty, tx, sw, sy, sx};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(logic [31:0] v, int span);
    return v + 32'($urandom_range(2 * span)) - 32'(span);
  endfunction

  task automatic load_homography(input int mode);
    logic [63:0] r [6];
    r[0] = {COEF_ONE, 32'd0};
    r[1] = 64'd0;
    r[2] = {COEF_ONE, 32'd0};
    r[3] = 64'd0;
    r[4] = 64'(COEF_ONE);
    r[5] = 64'd1 << 17;
    case (mode)
      1: begin
        r[1] = {near(32'd0, 1 << 22), near(32'd0, 4096)};
        r[5] = 64'($urandom_range(1 << 20));
      end
      2: begin
        r[0] = {32'h7FFF_FFFF, 32'h8000_0000};
        r[1] = {32'h7FFF_FFFF, 32'h8000_0000};
        r[2] = {32'h8000_0000, 32'h7FFF_FFFF};
        r[3] = {32'h7FFF_FFFF, 32'h8000_0000};
        r[4] = 64'h8000_0000;
        r[5] = 64'(DIST_SAT);
      end
      3: begin
        r[3] = {near(32'd0, 64), near(32'd0, 64)};
        r[5] = 64'd0;
      end
      4: begin
        for (int i = 0; i < 4; i++) r[i] = {$urandom, $urandom};
        r[4] = 64'($urandom);
        r[5] = {$urandom, $urandom} & 64'(DIST_SAT);
      end
      5: begin
        r[4] = 64'(COEF_ONE) << 1;
        r[0] = {COEF_ONE << 1, 32'd0};
        r[2] = {COEF_ONE << 1, 32'd0};
        r[5] = 64'd1 << 20;
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) write_reg(CFG_IDX_W'(i), r[i]);
  endtask

  task automatic random_point(input logic last);
    logic [31:0] sx, sy, sw;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      sx = near(32'd0, 1 << 24);
      sy = near(32'd0, 1 << 24);
      sw = ($urandom_range(9) == 0) ? near(32'h0001_0000, 1 << 16) : 32'h0001_0000;
      send_point(sx, sy, sw, near(sx, 1 << 17), near(sy, 1 << 17),
                 ($urandom_range(3) == 0) ? near(32'h0001_0000, 1 << 15) : 32'h0001_0000,
                 last);
    end else if (pick < 80) begin
      send_point($urandom, $urandom, 32'd0, $urandom, $urandom, $urandom, last);
    end else begin
      send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    hold_req = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first, zero threshold so nothing passes
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0000_0000, 32'h0000_0000,
               32'h0, 32'h0, 32'h0001_0000, 1'b1);
    wait_idle();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    load_homography(0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0000_0000,
               32'h0, 32'h0, 32'h0001_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
               32'h0, 32'h0, 32'h0001_0000, 1'b0);
    send_point(32'h0004_0000, 32'h0002_0000, 32'hFFFF_0000,
               32'hFFFC_0000, 32'hFFFE_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0100, 32'h0000_FF00, 32'h0001_0000, 1'b0);
    send_point(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
    send_point(32'h0000_8000, 32'h0, 32'h0000_8000, 32'h0001_0000, 32'h0,
               32'h0001_0000, 1'b1);
    wait_idle();
    load_homography(2);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h0, 32'h0, 32'h0001_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
               32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle = 36; recv_idle = 83; end
        1: begin send_idle = 83; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      load_homography(phase);
      for (int n = 0; n < 265; n++) begin
        if (phase == 2 && n == 40) hold_req <= 1'b1;
        if (phase == 0 && n == 100) wait_idle();
        random_point($urandom_range(11) == 0 || n == 264);
      end
      wait_idle();
    end

    $display("scored %0d points with %0d inliers over six homography settings", scored,
             inliers_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/hisc_pkg.sv
hdl/hisc_ctrl.sv
hdl/hisc_dpath.sv
hdl/homography_inlier_scorer.sv
verif/hisc_checker.sv
verif/tb_top.sv
